>>> rtl/bel_pkg.sv
// bel_pkg: shared types and constants for the button edge latch array
// holds the command codes and the item and result structs
// no dependencies
`default_nettype none

package bel_pkg;

  localparam int unsigned NumButtonsDef = 32;
  localparam int unsigned IndexW        = 8;

  typedef enum logic [2:0] {
    CmdPoll         = 3'd0,
    CmdPress        = 3'd1,
    CmdRelease      = 3'd2,
    CmdClearButton  = 3'd3,
    CmdClearPress   = 3'd4,
    CmdClearRelease = 3'd5,
    CmdClearAll     = 3'd6,
    CmdQuery        = 3'd7
  } bel_cmd_e;

  typedef struct packed {
    bel_cmd_e          command;
    logic [IndexW-1:0] button_index;
    logic              level;
  } bel_in_t;

  typedef struct packed {
    logic index_valid;
    logic is_down;
    logic was_pressed;
    logic was_repeated;
    logic was_released;
    logic any_pressed;
    logic any_released;
    logic any_down;
  } bel_out_t;

endpackage

`default_nettype wire

>>> rtl/bel_flag_array.sv
// bel_flag_array: the four sticky flag vectors and their per-command update
// returns the addressed button's flags after the update and the reductions
// depends on bel_pkg
`default_nettype none

module bel_flag_array import bel_pkg::*; #(
  parameter int unsigned NumButtons = NumButtonsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire bel_in_t  item_i,
  output bel_out_t      result_o
);

  logic [NumButtons-1:0] down_q, down_d;
  logic [NumButtons-1:0] pressed_q, pressed_d;
  logic [NumButtons-1:0] repeat_q, repeat_d;
  logic [NumButtons-1:0] released_q, released_d;
  logic [NumButtons-1:0] hit;
  logic                  index_valid;

  assign index_valid = ({1'b0, item_i.button_index} < (IndexW+1)'(NumButtons));

  always_comb begin
    down_d     = down_q;
    pressed_d  = pressed_q;
    repeat_d   = repeat_q;
    released_d = released_q;
    for (int unsigned i = 0; i < NumButtons; i++) begin
      hit[i] = index_valid && (item_i.button_index == IndexW'(i));
      if (valid_i) begin
        if (item_i.command == CmdClearAll) begin
          pressed_d[i]  = 1'b0;
          repeat_d[i]   = 1'b0;
          released_d[i] = 1'b0;
        end else if (hit[i]) begin
          unique case (item_i.command)
            CmdPoll: begin
              down_d[i] = item_i.level;
              if (down_q[i] && !item_i.level) begin
                released_d[i] = 1'b1;
              end
              if (!down_q[i] && item_i.level) begin
                pressed_d[i] = 1'b1;
                repeat_d[i]  = 1'b1;
              end
            end
            CmdPress: begin
              repeat_d[i] = 1'b1;
              if (!down_q[i]) begin
                pressed_d[i] = 1'b1;
                down_d[i]    = 1'b1;
              end
            end
            CmdRelease: begin
              if (down_q[i]) begin
                released_d[i] = 1'b1;
                down_d[i]     = 1'b0;
              end
            end
            CmdClearButton: begin
              down_d[i]     = 1'b0;
              pressed_d[i]  = 1'b0;
              repeat_d[i]   = 1'b0;
              released_d[i] = 1'b0;
            end
            CmdClearPress: begin
              pressed_d[i] = 1'b0;
              repeat_d[i]  = 1'b0;
            end
            CmdClearRelease: begin
              released_d[i] = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q     <= '0;
      pressed_q  <= '0;
      repeat_q   <= '0;
      released_q <= '0;
    end else begin
      down_q     <= down_d;
      pressed_q  <= pressed_d;
      repeat_q   <= repeat_d;
      released_q <= released_d;
    end
  end

  // hit is zero for an out-of-range index, so those fields read as zero
  always_comb begin
    result_o.index_valid  = index_valid;
    result_o.is_down      = |(down_d & hit);
    result_o.was_pressed  = |(pressed_d & hit);
    result_o.was_repeated = |(repeat_d & hit);
    result_o.was_released = |(released_d & hit);
    result_o.any_pressed  = |pressed_d;
    result_o.any_released = |released_d;
    result_o.any_down     = |down_d;
  end

  a_press_implies_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pressed_q & ~repeat_q) == '0)
    else $error("pressed flag set without repeat flag");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && item_i.command == CmdClearAll |=> pressed_q == '0 && released_q == '0)
    else $error("clear all left press or release flags");

  a_clear_all_keeps_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && item_i.command == CmdClearAll |=> down_q == $past(down_q))
    else $error("clear all changed down flags");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |=> $stable(down_q) && $stable(pressed_q) && $stable(released_q))
    else $error("flags changed without a transfer");

endmodule

`default_nettype wire

>>> rtl/button_edge_latch_array.sv
// button_edge_latch_array: top level, input register, flag array and result register
// depends on bel_pkg and bel_flag_array
//
//   channel  | ports                          | transfer
//   ---------+--------------------------------+-------------------------------
//   command  | start, busy, item_i            | edge with start high, busy low
//   result   | result_valid_o, result_o       | edge ending the strobe cycle
//
// one item per cycle; busy stays low, every cycle can take a transfer
// the input register holds the accepted item, the flag update is then registered
// into the result register, and the valid bit of that register drives the strobe
// reset clears all flags and both valid bits; the receiver cannot stall
`default_nettype none

module button_edge_latch_array import bel_pkg::*; #(
  parameter int unsigned NumButtons = NumButtonsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire bel_in_t  item_i,
  output logic          result_valid_o,
  output bel_out_t      result_o
);

  logic     in_valid_q;
  bel_in_t  in_q;
  logic     res_valid_q;
  bel_out_t res_q;
  bel_out_t res_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start && !busy;
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= item_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  bel_flag_array #(
    .NumButtons(NumButtons)
  ) u_flags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .item_i   (in_q),
    .result_o (res_d)
  );

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.index_valid |->
      !result_o.is_down && !result_o.was_pressed &&
      !result_o.was_repeated && !result_o.was_released)
    else $error("out-of-range index reported flags");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |=> ##1 !result_valid_o)
    else $error("result without an accepted item");

endmodule

`default_nettype wire

>>> tb/tb_button_edge_latch_array.sv
// tb_button_edge_latch_array: self-checking testbench for button_edge_latch_array
// walks a directed table, then weighted random commands; expected flags: predictor or typed row
// depends on bel_pkg and the rtl of button_edge_latch_array
`default_nettype none

module tb_button_edge_latch_array import bel_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BTN_COUNT    = NumButtonsDef;
  localparam int unsigned CYCLE_LIMIT  = 50000;
  localparam int unsigned PHASE_ITEMS  = 185;
  localparam int unsigned SETTLE_EDGES = 4;
  localparam int unsigned DIR_ROWS     = 21;

  localparam bel_out_t ALL_CLEAR  = '0;
  localparam bel_out_t ONLY_VALID = '{index_valid: 1'b1, default: 1'b0};

  typedef struct packed {
    bel_in_t  item;
    logic     typed;
    bel_out_t flags;
  } dir_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  bel_in_t  item_i;
  logic     result_valid_o;
  bel_out_t result_o;

  bit [BTN_COUNT-1:0] btn_down;
  bit [BTN_COUNT-1:0] btn_pressed;
  bit [BTN_COUNT-1:0] btn_repeat;
  bit [BTN_COUNT-1:0] btn_released;

  bel_out_t    flags_due[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  dir_row_t    directed_rows [DIR_ROWS];

  button_edge_latch_array dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bel_out_t step_flags(bel_in_t it);
    bel_out_t    r;
    logic        ok;
    logic        prev_down;
    int unsigned b;
    ok = it.button_index < BTN_COUNT;
    b  = 32'(it.button_index);
    r  = '0;
    if (it.command == CmdClearAll) begin
      btn_pressed  = '0;
      btn_repeat   = '0;
      btn_released = '0;
    end else if (ok) begin
      prev_down = btn_down[b];
      case (it.command)
        CmdPoll: begin
          btn_down[b] = it.level;
          if (prev_down && !it.level) btn_released[b] = 1'b1;
          if (!prev_down && it.level) begin
            btn_pressed[b] = 1'b1;
            btn_repeat[b]  = 1'b1;
          end
        end
        CmdPress: begin
          btn_repeat[b] = 1'b1;
          if (!prev_down) begin
            btn_pressed[b] = 1'b1;
            btn_down[b]    = 1'b1;
          end
        end
        CmdRelease: begin
          if (prev_down) begin
            btn_released[b] = 1'b1;
            btn_down[b]     = 1'b0;
          end
        end
        CmdClearButton: begin
          btn_down[b]     = 1'b0;
          btn_pressed[b]  = 1'b0;
          btn_repeat[b]   = 1'b0;
          btn_released[b] = 1'b0;
        end
        CmdClearPress: begin
          btn_pressed[b] = 1'b0;
          btn_repeat[b]  = 1'b0;
        end
        CmdClearRelease: begin
          btn_released[b] = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (ok) begin
      r.index_valid  = 1'b1;
      r.is_down      = btn_down[b];
      r.was_pressed  = btn_pressed[b];
      r.was_repeated = btn_repeat[b];
      r.was_released = btn_released[b];
    end
    r.any_pressed  = |btn_pressed;
    r.any_released = |btn_released;
    r.any_down     = |btn_down;
    return r;
  endfunction

  function automatic bel_in_t random_item();
    bel_in_t     it;
    int unsigned pick;
    it.level = 1'($urandom_range(1));
    pick = $urandom_range(99);
    // mostly a few busy buttons so event sequences build up on the same flags
    if (pick < 8) begin
      it.button_index = 8'($urandom_range(255, BTN_COUNT));
    end else if (pick < 70) begin
      it.button_index = 8'($urandom_range(3));
    end else begin
      it.button_index = 8'($urandom_range(BTN_COUNT - 1));
    end
    pick = $urandom_range(99);
    if (pick < 30)      it.command = CmdPoll;
    else if (pick < 50) it.command = CmdPress;
    else if (pick < 68) it.command = CmdRelease;
    else if (pick < 74) it.command = CmdClearButton;
    else if (pick < 80) it.command = CmdClearPress;
    else if (pick < 86) it.command = CmdClearRelease;
    else if (pick < 89) it.command = CmdClearAll;
    else                it.command = CmdQuery;
    return it;
  endfunction

  task automatic drive_item(input bel_in_t it, input int unsigned idle_pct,
                            input logic typed, input bel_out_t typed_flags);
    bel_out_t want;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = step_flags(it);
    if (typed) want = typed_flags;
    flags_due.push_back(want);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (flags_due.size() != 0);
  endtask

  task automatic check_flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s expected %b got %b", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bel_out_t want;
    if (rst_ni && result_valid_o) begin
      if (flags_due.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none got %b", $time, result_o);
        error_count++;
      end else begin
        want = flags_due.pop_front();
        check_flag("index_valid",  want.index_valid,  result_o.index_valid);
        check_flag("is_down",      want.is_down,      result_o.is_down);
        check_flag("was_pressed",  want.was_pressed,  result_o.was_pressed);
        check_flag("was_repeated", want.was_repeated, result_o.was_repeated);
        check_flag("was_released", want.was_released, result_o.was_released);
        check_flag("any_pressed",  want.any_pressed,  result_o.any_pressed);
        check_flag("any_released", want.any_released, result_o.any_released);
        check_flag("any_down",     want.any_down,     result_o.any_down);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, flags_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned idle_by_phase [4];
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;
    btn_down     = '0;
    btn_pressed  = '0;
    btn_repeat   = '0;
    btn_released = '0;
    idle_by_phase = '{0, 47, 19, 0};

    // fresh after reset, out of range, edges, events, clears
    directed_rows = '{
      '{'{CmdQuery,        8'd0,   1'b0}, 1'b1, ONLY_VALID},
      '{'{CmdQuery,        8'd255, 1'b1}, 1'b1, ALL_CLEAR},
      '{'{CmdPoll,         8'd0,   1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdPoll,         8'd31,  1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdPoll,         8'd31,  1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdPoll,         8'd31,  1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdPress,        8'd5,   1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdPress,        8'd5,   1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdRelease,      8'd5,   1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdRelease,      8'd5,   1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdPress,        8'd32,  1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdPoll,         8'd255, 1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdRelease,      8'd200, 1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdClearPress,   8'd0,   1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdClearRelease, 8'd31,  1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdClearButton,  8'd5,   1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdClearRelease, 8'd128, 1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdClearAll,     8'd255, 1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdQuery,        8'd0,   1'b0}, 1'b0, ALL_CLEAR},
      '{'{CmdClearButton,  8'd0,   1'b1}, 1'b0, ALL_CLEAR},
      '{'{CmdQuery,        8'd31,  1'b1}, 1'b1, ONLY_VALID}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].item, 0, directed_rows[i].typed, directed_rows[i].flags);
    end

    foreach (idle_by_phase[p]) begin
      repeat (PHASE_ITEMS) drive_item(random_item(), idle_by_phase[p], 1'b0, ALL_CLEAR);
      if (p == 1) drain_results();
    end

    drain_results();
    repeat (SETTLE_EDGES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
